// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/core/bfs_pkg.sv =====
// Types and constants of the bounded queue with statistics.
package bfs_pkg;

  localparam int ValW = 32;
  localparam int CntW = 32;
  localparam int OccW = 7;
  localparam int CapW = 7;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [0:0] {
    OP_ADD = 1'b0,
    OP_GET = 1'b1
  } bfs_op_e;

  typedef struct packed {
    logic            ok;
    logic            is_get;
    logic [OccW-1:0] occupancy;
    logic [CntW-1:0] add_tries;
    logic [CntW-1:0] get_tries;
    logic [CntW-1:0] adds_done;
    logic [CntW-1:0] gets_done;
  } bfs_status_t;

endpackage

// ===== rtl/core/bounded_fifo_with_statistics.sv =====
// Top level of the bounded queue with statistics: stream ports, store and result register.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/tready         tuser: op; tdata: value
//  m_axis    out  m_axis_tvalid/tready         tuser: ok; tdata: data, occupancy, counters
//  cfg       in   cfg_we_i                     cfg_wdata_i: capacity
//
// One word per cycle unless the output stalls; results pass read stage, then result register.
// The store read of a get lands in the cycle after acceptance, then the result register.
// Reset clears pointers, fill and counters and sets capacity to 64; the store is not cleared.
// A stalled result stops input only once the read stage is also occupied.
`include "assert_macros.svh"

module bounded_fifo_with_statistics #(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,   // [31:0] value
  input  logic [0:0]               s_axis_tuser,   // [0] op
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [167:0]             m_axis_tdata,   // [31:0] data_out, [38:32] occupancy,
                                                   // [70:39] add_tries, [102:71] get_tries,
                                                   // [134:103] adds_done, [166:135] gets_done,
                                                   // [167] zero
  output logic [0:0]               m_axis_tuser,   // [0] ok
  input  logic                     cfg_we_i,
  input  logic [bfs_pkg::CapW-1:0] cfg_wdata_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     accept;
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_move;
  logic                     out_valid_q, out_valid_d;
  logic [167:0]             out_data_q;
  logic [0:0]               out_user_q;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [bfs_pkg::ValW-1:0] mem_rdata;
  logic [bfs_pkg::ValW-1:0] data_sel;
  bfs_pkg::bfs_status_t     status;

  bfs_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(accept),
    .op_i        (bfs_pkg::bfs_op_e'(s_axis_tuser[0])),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .status_o    (status)
  );

  bfs_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (bfs_pkg::ValW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(s_axis_tdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign data_sel      = (status.ok && status.is_get) ? mem_rdata : '0;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= {1'b0, status.gets_done, status.adds_done, status.get_tries,
                     status.add_tries, status.occupancy, data_sel};
      out_user_q <= status.ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `ASSERT_AT(a_stall_blocks, s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready,
             "word taken while result path is full")
  `ASSERT_AT(a_fail_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0,
             "refused operation carries nonzero data")

endmodule

// ===== rtl/core/bfs_ram.sv =====
// Ring store: one write port, one read port, registered read data.
module bfs_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bfs_ctrl.sv =====
// Queue control: pointers, fill count, capacity register and saturating statistics.
`include "assert_macros.svh"

module bfs_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  input  bfs_pkg::bfs_op_e                  op_i,
  input  logic                              cfg_we_i,
  input  logic [bfs_pkg::CapW-1:0]          cfg_wdata_i,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic                              mem_re_o,
  output logic [AW-1:0]                     mem_raddr_o,
  output bfs_pkg::bfs_status_t              status_o
);

  localparam int DepthW = $clog2(DEPTH + 1);
  localparam int CmpW   = (DepthW > bfs_pkg::CapW) ? DepthW : bfs_pkg::CapW;
  localparam logic [CmpW-1:0] DepthC   = CmpW'(DEPTH);
  localparam logic [AW-1:0]   LastAddr = AW'(DEPTH - 1);

  logic [bfs_pkg::CapW-1:0] cap_q;
  logic [AW-1:0]            head_q, head_d;
  logic [AW-1:0]            tail_q, tail_d;
  logic [bfs_pkg::OccW-1:0] fill_q, fill_d;
  logic [bfs_pkg::CntW-1:0] add_try_q, add_try_d;
  logic [bfs_pkg::CntW-1:0] get_try_q, get_try_d;
  logic [bfs_pkg::CntW-1:0] add_done_q, add_done_d;
  logic [bfs_pkg::CntW-1:0] get_done_q, get_done_d;
  logic                     ok_q, ok_d;
  logic                     is_get_q, is_get_d;
  logic                     add_ok, get_ok, do_add, do_get;

  function automatic logic [bfs_pkg::CntW-1:0] sat_inc(input logic [bfs_pkg::CntW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign add_ok = (CmpW'(fill_q) < CmpW'(cap_q)) && (CmpW'(fill_q) < DepthC);
  assign get_ok = (fill_q != '0);
  assign do_add = item_valid_i && (op_i == bfs_pkg::OP_ADD) && add_ok;
  assign do_get = item_valid_i && (op_i == bfs_pkg::OP_GET) && get_ok;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    add_try_d  = add_try_q;
    get_try_d  = get_try_q;
    add_done_d = add_done_q;
    get_done_d = get_done_q;
    ok_d       = ok_q;
    is_get_d   = is_get_q;
    if (item_valid_i) begin
      is_get_d = (op_i == bfs_pkg::OP_GET);
      ok_d     = do_add || do_get;
      if (op_i == bfs_pkg::OP_ADD) begin
        add_try_d = sat_inc(add_try_q);
      end else begin
        get_try_d = sat_inc(get_try_q);
      end
    end
    if (do_add) begin
      tail_d     = (tail_q == LastAddr) ? '0 : tail_q + 1'b1;
      fill_d     = fill_q + 1'b1;
      add_done_d = sat_inc(add_done_q);
    end
    if (do_get) begin
      head_d     = (head_q == LastAddr) ? '0 : head_q + 1'b1;
      fill_d     = fill_q - 1'b1;
      get_done_d = sat_inc(get_done_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= bfs_pkg::CapReset;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      add_try_q  <= '0;
      get_try_q  <= '0;
      add_done_q <= '0;
      get_done_q <= '0;
      ok_q       <= 1'b0;
      is_get_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      add_try_q  <= add_try_d;
      get_try_q  <= get_try_d;
      add_done_q <= add_done_d;
      get_done_q <= get_done_d;
      ok_q       <= ok_d;
      is_get_q   <= is_get_d;
    end
  end

  assign mem_we_o    = do_add;
  assign mem_waddr_o = tail_q;
  assign mem_re_o    = do_get;
  assign mem_raddr_o = head_q;

  assign status_o.ok        = ok_q;
  assign status_o.is_get    = is_get_q;
  assign status_o.occupancy = fill_q;
  assign status_o.add_tries = add_try_q;
  assign status_o.get_tries = get_try_q;
  assign status_o.adds_done = add_done_q;
  assign status_o.gets_done = get_done_q;

  `ASSERT_AT(a_add_fill, do_add |=> fill_q == $past(fill_q) + 1'b1, "add did not raise fill")
  `ASSERT_NEVER(a_done_tries, (add_done_q > add_try_q) || (get_done_q > get_try_q),
                "done count exceeds try count")

endmodule
